@@ src/lbcd_pkg.sv @@
// Shared types and constants for the LRU buffer cache directory.
`default_nettype none
package lbcd_pkg;

    localparam int OPCODE_W   = 2;
    localparam int BLOCK_W    = 32;
    localparam int SLOT_IDX_W = 6;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int THR_W      = 7;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int GRP_SIZE   = 8;
    localparam int RESET_KEEP = 32;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(RESET_KEEP);
    localparam logic             REG_KEEP_THRESHOLD = 1'b0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_BUSY   = 2'd1,
        STS_FULL   = 2'd2,
        STS_ABSENT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_REDUCE,
        S_UPDATE
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic reduce;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } ctrl_sts_t;

endpackage
`default_nettype wire

@@ src/lbcd_if.sv @@
// Request and response channel interfaces.
`default_nettype none
interface lbcd_req_if;
    logic                           valid;
    logic                           ready;
    logic [lbcd_pkg::OPCODE_W-1:0]  opcode;
    logic [lbcd_pkg::BLOCK_W-1:0]   block_tag;
    logic [lbcd_pkg::SLOT_IDX_W-1:0] slot_index;

    modport source (output valid, opcode, block_tag, slot_index, input ready);
    modport sink (input valid, opcode, block_tag, slot_index, output ready);
endinterface

interface lbcd_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [lbcd_pkg::STATUS_W-1:0]   status;
    logic [lbcd_pkg::SLOT_IDX_W-1:0] slot_out;
    logic                            hit;
    logic                            need_read;
    logic                            removed;
    logic [lbcd_pkg::COUNT_W-1:0]    entry_count;

    modport source (output valid, status, slot_out, hit, need_read, removed, entry_count,
                    input ready);
    modport sink (input valid, status, slot_out, hit, need_read, removed, entry_count,
                  output ready);
endinterface
`default_nettype wire

@@ src/lru_buffer_cache_directory.sv @@
// Top level of the LRU buffer cache directory.
//
// Requests enter on req (acquire, release, pin, unpin); each produces one
// response beat on rsp with status, slot, hit, need_read, removed and the
// entry count after the request.
// One request is in work at a time. After a request beat is accepted, the
// sequence is capture, tag lookup into registered per-group winners, final
// reduction over the groups, and the entry update that loads the response
// register and makes the response beat valid.
// A new request may be accepted while the previous response still waits.
// If rsp stalls, the update of the following request holds until the
// response register frees, and req stays not ready.
// keep_threshold sits at APB byte address 0; writes take effect at once.
// Reset makes the first min(32, CAPACITY) slots present in index order,
// with zero tags, all flags clear and keep_threshold at 32.
`default_nettype none
module lru_buffer_cache_directory #(
    parameter int CAPACITY  = 64,
    parameter int TAG_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    lbcd_req_if.sink                             req,
    lbcd_rsp_if.source                           rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lbcd_pkg::APB_AW-1:0]     paddr,
    input  wire logic [lbcd_pkg::APB_DW-1:0]     pwdata,
    output logic [lbcd_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);
    import lbcd_pkg::*;

    logic [THR_W-1:0] keep_threshold_reg;
    ctrl_cmd_t        cmd;
    ctrl_sts_t        sts;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1] == REG_KEEP_THRESHOLD);
    assign prdata  = reg_sel ? APB_DW'(keep_threshold_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_threshold_reg <= THR_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            keep_threshold_reg <= pwdata[THR_W-1:0];
        end
    end

    lbcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lbcd_datapath #(
        .CAPACITY  (CAPACITY),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .keep_threshold  (keep_threshold_reg),
        .in_opcode       (req.opcode),
        .in_block_tag    (req.block_tag),
        .in_slot_index   (req.slot_index),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_status      (rsp.status),
        .out_slot        (rsp.slot_out),
        .out_hit         (rsp.hit),
        .out_need_read   (rsp.need_read),
        .out_removed     (rsp.removed),
        .out_entry_count (rsp.entry_count)
    );
endmodule
`default_nettype wire

@@ src/lbcd_ctrl.sv @@
// Sequencer for lookup, reduction and update of one request.
`default_nettype none
module lbcd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lbcd_pkg::ctrl_sts_t sts,
    output lbcd_pkg::ctrl_cmd_t      cmd
);
    import lbcd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_LOOKUP;
            S_LOOKUP: state_next = S_REDUCE;
            S_REDUCE: state_next = S_UPDATE;
            S_UPDATE: if (sts.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_LOOKUP: cmd.lookup = 1'b1;
            S_REDUCE: cmd.reduce = 1'b1;
            S_UPDATE: cmd.update = sts.out_free;
            default:  cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ src/lbcd_datapath.sv @@
// Directory entries, parallel tag search, recency update and response register.
`default_nettype none
module lbcd_datapath #(
    parameter int CAPACITY  = 64,
    parameter int TAG_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lbcd_pkg::ctrl_cmd_t                 cmd,
    output lbcd_pkg::ctrl_sts_t                      sts,
    input  wire logic [lbcd_pkg::THR_W-1:0]          keep_threshold,
    input  wire logic [lbcd_pkg::OPCODE_W-1:0]       in_opcode,
    input  wire logic [lbcd_pkg::BLOCK_W-1:0]        in_block_tag,
    input  wire logic [lbcd_pkg::SLOT_IDX_W-1:0]     in_slot_index,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [lbcd_pkg::STATUS_W-1:0]            out_status,
    output logic [lbcd_pkg::SLOT_IDX_W-1:0]          out_slot,
    output logic                                     out_hit,
    output logic                                     out_need_read,
    output logic                                     out_removed,
    output logic [lbcd_pkg::COUNT_W-1:0]             out_entry_count
);
    import lbcd_pkg::*;

    localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int NGRP    = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int RESET_N = (RESET_KEEP < CAPACITY) ? RESET_KEEP : CAPACITY;
    localparam int NSRCH   = 4;
    localparam int SR_HIT  = 0;
    localparam int SR_VIC  = 1;
    localparam int SR_FREE = 2;
    localparam int SR_SEL  = 3;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
        logic [SLOT_W-1:0] key;
        logic [2:0]        attr;
    } cand_t;

    function automatic cand_t pick(cand_t a, cand_t b, logic want_max);
        cand_t r;
        r = a;
        if (b.found && !a.found)
        begin
            r = b;
        end
        else if (b.found && (want_max ? (b.key > a.key) : (b.key < a.key)))
        begin
            r = b;
        end
        return r;
    endfunction

    opcode_t                op_reg;
    logic [TAG_WIDTH-1:0]   req_tag_reg;
    logic [SLOT_IDX_W-1:0]  req_slot_reg;

    logic [TAG_WIDTH-1:0]   cell_tag_reg  [CAPACITY];
    logic [SLOT_W-1:0]      rank_reg      [CAPACITY];
    logic [CAPACITY-1:0]    present_reg;
    logic [CAPACITY-1:0]    held_reg;
    logic [CAPACITY-1:0]    pinned_reg;
    logic [CAPACITY-1:0]    valid_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    cand_t cand_c   [NSRCH][CAPACITY];
    cand_t grp_next [NSRCH][NGRP];
    cand_t grp_reg  [NSRCH][NGRP];
    cand_t res_next [NSRCH];
    cand_t res_reg  [NSRCH];

    logic              slot_ok;
    logic [SLOT_W-1:0] slot_sel;

    logic              out_valid_reg;
    status_t           status_next;
    logic [SLOT_IDX_W-1:0] slot_out_next;
    logic              hit_next;
    logic              rd_next;
    logic              rem_next;

    logic              act_hitset;
    logic              act_read;
    logic              act_fill;
    logic              act_new;
    logic              act_rel;
    logic              act_remove;
    logic              act_front;
    logic              act_pin;
    logic              act_unpin;
    logic [SLOT_W-1:0] tgt;
    logic [SLOT_W-1:0] sel_rank;

    assign slot_ok  = (32'(req_slot_reg) < 32'(CAPACITY));
    assign slot_sel = SLOT_W'(req_slot_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= opcode_t'(in_opcode);
            req_tag_reg  <= TAG_WIDTH'(in_block_tag);
            req_slot_reg <= in_slot_index;
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cand_c[SR_HIT][i].found  = present_reg[i] && (cell_tag_reg[i] == req_tag_reg);
            cand_c[SR_HIT][i].idx    = SLOT_W'(i);
            cand_c[SR_HIT][i].key    = rank_reg[i];
            cand_c[SR_HIT][i].attr   = {held_reg[i], valid_reg[i], pinned_reg[i]};
            cand_c[SR_VIC][i].found  = present_reg[i] && !held_reg[i] && !pinned_reg[i];
            cand_c[SR_VIC][i].idx    = SLOT_W'(i);
            cand_c[SR_VIC][i].key    = rank_reg[i];
            cand_c[SR_VIC][i].attr   = '0;
            cand_c[SR_FREE][i].found = !present_reg[i];
            cand_c[SR_FREE][i].idx   = SLOT_W'(i);
            cand_c[SR_FREE][i].key   = SLOT_W'(i);
            cand_c[SR_FREE][i].attr  = '0;
            cand_c[SR_SEL][i].found  = present_reg[i] && slot_ok && (SLOT_W'(i) == slot_sel);
            cand_c[SR_SEL][i].idx    = SLOT_W'(i);
            cand_c[SR_SEL][i].key    = rank_reg[i];
            cand_c[SR_SEL][i].attr   = {2'b00, pinned_reg[i]};
        end
    end

    always_comb
    begin
        for (int s = 0; s < NSRCH; s++)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                grp_next[s][g] = '0;
                for (int j = 0; j < GRP_SIZE; j++)
                begin
                    if (g * GRP_SIZE + j < CAPACITY)
                    begin
                        grp_next[s][g] = pick(grp_next[s][g], cand_c[s][g * GRP_SIZE + j],
                                              s == SR_VIC);
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < NSRCH; s++)
        begin
            res_next[s] = '0;
            for (int g = 0; g < NGRP; g++)
            begin
                res_next[s] = pick(res_next[s], grp_reg[s][g], s == SR_VIC);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            grp_reg <= grp_next;
        end
        if (cmd.reduce)
        begin
            res_reg <= res_next;
        end
    end

    assign sel_rank = res_reg[SR_SEL].key;

    always_comb
    begin
        act_hitset    = 1'b0;
        act_read      = 1'b0;
        act_fill      = 1'b0;
        act_new       = 1'b0;
        act_rel       = 1'b0;
        act_remove    = 1'b0;
        act_front     = 1'b0;
        act_pin       = 1'b0;
        act_unpin     = 1'b0;
        tgt           = slot_sel;
        status_next   = STS_OK;
        slot_out_next = req_slot_reg;
        hit_next      = 1'b0;
        rd_next       = 1'b0;
        rem_next      = 1'b0;
        count_next    = count_reg;
        if (op_reg == OP_ACQUIRE)
        begin
            if (res_reg[SR_HIT].found)
            begin
                tgt      = res_reg[SR_HIT].idx;
                hit_next = 1'b1;
                if (res_reg[SR_HIT].attr[2])
                begin
                    status_next = STS_BUSY;
                end
                else
                begin
                    act_hitset = 1'b1;
                    act_read   = !res_reg[SR_HIT].attr[1] && !res_reg[SR_HIT].attr[0];
                    rd_next    = act_read;
                end
            end
            else if (res_reg[SR_VIC].found)
            begin
                tgt      = res_reg[SR_VIC].idx;
                act_fill = 1'b1;
                rd_next  = 1'b1;
            end
            else if ((32'(count_reg) < 32'(CAPACITY)) && res_reg[SR_FREE].found)
            begin
                tgt        = res_reg[SR_FREE].idx;
                act_fill   = 1'b1;
                act_new    = 1'b1;
                rd_next    = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                status_next = STS_FULL;
            end
            slot_out_next = (status_next == STS_FULL) ? '0 : SLOT_IDX_W'(tgt);
        end
        else if (!res_reg[SR_SEL].found)
        begin
            status_next = STS_ABSENT;
        end
        else
        begin
            unique case (op_reg)
                OP_RELEASE:
                begin
                    act_rel = 1'b1;
                    if (!res_reg[SR_SEL].attr[0] &&
                        ((32'(count_reg) - 32'd1) > 32'(keep_threshold)))
                    begin
                        act_remove = 1'b1;
                        rem_next   = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        act_front = 1'b1;
                    end
                end
                OP_PIN:   act_pin = 1'b1;
                OP_UNPIN: act_unpin = 1'b1;
                default:  act_pin = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                cell_tag_reg[i] <= '0;
                rank_reg[i]     <= SLOT_W'(i);
                present_reg[i]  <= (i < RESET_N);
            end
            held_reg   <= '0;
            pinned_reg <= '0;
            valid_reg  <= '0;
            count_reg  <= CNT_W'(RESET_N);
        end
        else if (cmd.update)
        begin
            count_reg <= count_next;
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (SLOT_W'(i) == tgt)
                begin
                    if (act_hitset || act_fill) held_reg[i] <= 1'b1;
                    if (act_read || act_fill) valid_reg[i] <= 1'b1;
                    if (act_fill) cell_tag_reg[i] <= req_tag_reg;
                    if (act_new)
                    begin
                        present_reg[i] <= 1'b1;
                        pinned_reg[i]  <= 1'b0;
                        rank_reg[i]    <= SLOT_W'(count_reg);
                    end
                    if (act_rel) held_reg[i] <= 1'b0;
                    if (act_remove)
                    begin
                        present_reg[i]  <= 1'b0;
                        valid_reg[i]    <= 1'b0;
                        cell_tag_reg[i] <= '0;
                    end
                    if (act_front) rank_reg[i] <= '0;
                    if (act_pin) pinned_reg[i] <= 1'b1;
                    if (act_unpin) pinned_reg[i] <= 1'b0;
                end
                else if (present_reg[i])
                begin
                    if (act_remove && (rank_reg[i] > sel_rank))
                        rank_reg[i] <= rank_reg[i] - SLOT_W'(1);
                    if (act_front && (rank_reg[i] < sel_rank))
                        rank_reg[i] <= rank_reg[i] + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_status      <= status_next;
            out_slot        <= slot_out_next;
            out_hit         <= hit_next;
            out_need_read   <= rd_next;
            out_removed     <= rem_next;
            out_entry_count <= COUNT_W'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.out_free = !out_valid_reg || out_ready;
endmodule
`default_nettype wire
